// ----- rtl/core/u8d_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the utf-8 stream decoder
package u8d_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CP_W   = 31;
	localparam int unsigned PEND_W = 3;

	// continuation payload bits per trailing byte
	localparam int unsigned SEXT_W = 6;

	// most trailing bytes a lead byte can announce (six-byte form)
	localparam logic [PEND_W-1:0] MAX_PENDING = 3'd5;

	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic            bad_lead;
	} u8d_result_t;

	// what the decode stage hands to the result register
	typedef struct packed {
		logic        emit;
		u8d_result_t res;
	} u8d_step_t;

endpackage

// ----- rtl/core/u8d_if.sv -----
`timescale 1ns / 1ps
// valid/ready channel interfaces for raw bytes and decoded characters
interface u8d_byte_if;
	import u8d_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface u8d_char_if;
	import u8d_pkg::*;

	logic            valid;
	logic            ready;
	logic [CP_W-1:0] code_point;
	logic            bad_lead;

	modport source (output valid, output code_point, output bad_lead, input ready);
	modport sink (input valid, input code_point, input bad_lead, output ready);
endinterface

// ----- rtl/core/u8d_in_stage.sv -----
`timescale 1ns / 1ps
// input register for one raw byte
module u8d_in_stage (
	input  logic                    clk,
	input  logic                    arst_n,
	u8d_byte_if.sink                stream,
	input  logic                    adv,
	output logic                    valid_s1,
	output logic [u8d_pkg::BYTE_W-1:0] byte_s1
);
	import u8d_pkg::*;

	logic take;

	assign stream.ready = !valid_s1 || adv;
	assign take         = stream.valid && stream.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= stream.in_byte;
		end
	end
endmodule

// ----- rtl/core/u8d_step.sv -----
`timescale 1ns / 1ps
// lead classification, accumulator and pending count
module u8d_step (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [u8d_pkg::BYTE_W-1:0] byte_s1,
	input  logic                       adv,
	output u8d_pkg::u8d_step_t         step
);
	import u8d_pkg::*;

	logic [PEND_W-1:0] pending_q;
	logic [CP_W-1:0]   partial_q;
	logic [PEND_W-1:0] pending_d;
	logic [CP_W-1:0]   partial_d;
	logic [CP_W-1:0]   shifted;

	// tag bits of a trailing byte are ignored
	assign shifted = {partial_q[CP_W-SEXT_W-1:0], byte_s1[SEXT_W-1:0]};

	always_comb begin
		pending_d             = pending_q;
		partial_d             = partial_q;
		step.emit             = 1'b0;
		step.res.code_point   = '0;
		step.res.bad_lead     = 1'b0;
		if (pending_q != '0) begin
			pending_d = pending_q - 3'd1;
			if (pending_q == 3'd1) begin
				partial_d           = '0;
				step.emit           = 1'b1;
				step.res.code_point = shifted;
			end else begin
				partial_d = shifted;
			end
		end else begin
			case (byte_s1) inside
				[8'h00:8'h7F]: begin
					step.emit           = 1'b1;
					step.res.code_point = {{(CP_W-BYTE_W){1'b0}}, byte_s1};
				end
				[8'hC0:8'hDF]: begin
					pending_d = 3'd1;
					partial_d = {{(CP_W-5){1'b0}}, byte_s1[4:0]};
				end
				[8'hE0:8'hEF]: begin
					pending_d = 3'd2;
					partial_d = {{(CP_W-4){1'b0}}, byte_s1[3:0]};
				end
				[8'hF0:8'hF7]: begin
					pending_d = 3'd3;
					partial_d = {{(CP_W-3){1'b0}}, byte_s1[2:0]};
				end
				[8'hF8:8'hFB]: begin
					pending_d = 3'd4;
					partial_d = {{(CP_W-2){1'b0}}, byte_s1[1:0]};
				end
				[8'hFC:8'hFD]: begin
					pending_d = MAX_PENDING;
					partial_d = {{(CP_W-1){1'b0}}, byte_s1[0]};
				end
				default: begin
					// stray continuation, fe or ff
					partial_d         = '0;
					step.emit         = 1'b1;
					step.res.bad_lead = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			partial_q <= '0;
		end else if (adv) begin
			pending_q <= pending_d;
			partial_q <= partial_d;
		end
	end

	a_pending_range: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= MAX_PENDING)
		else $error("pending count out of range");

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(pending_q == '0) |-> (partial_q == '0))
		else $error("accumulator not cleared while idle");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && pending_q != '0) |=> (pending_q == $past(pending_q) - 3'd1))
		else $error("pending count did not step down");
endmodule

// ----- rtl/core/u8d_out_stage.sv -----
`timescale 1ns / 1ps
// result register feeding the character channel
module u8d_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  u8d_pkg::u8d_result_t res,
	output logic               free,
	u8d_char_if.source         chars
);
	import u8d_pkg::*;

	logic        valid_q;
	u8d_result_t res_q;

	assign free             = !valid_q || chars.ready;
	assign chars.valid      = valid_q;
	assign chars.code_point = res_q.code_point;
	assign chars.bad_lead   = res_q.bad_lead;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (chars.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end
endmodule

// ----- rtl/core/utf8_stream_decoder_31bit.sv -----
`timescale 1ns / 1ps
// top level of the six-byte utf-8 stream decoder
// Decodes a byte stream in the original six-byte UTF-8 form into 31-bit code
// points. Bytes are taken on the stream channel; a lead byte sets how many
// trailing bytes follow (none for 00-7f, one to five for c0-fd) and seeds the
// accumulator, each trailing byte shifts in its low six bits without checking
// its tag, and the finished code point appears on the chars channel. Overlong
// forms pass through as decoded. A lead byte of 80-bf, fe or ff gives one
// result with bad_lead set and code_point zero, and the decoder stays idle.
// A request goes from the stream port into an input register, through one
// level of decode logic into the result register, at a sustained rate of
// one byte per cycle, set by the single accumulator update per byte, while
// no finished result is held up. Bytes that only feed the accumulator move
// on even while a finished result still waits in the result register.
module utf8_stream_decoder_31bit (
	input  logic       clk,
	input  logic       arst_n,
	u8d_byte_if.sink   stream,
	u8d_char_if.source chars
);
	import u8d_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              adv;
	logic              out_free;
	u8d_step_t         step;

	// a byte leaves the input register when its result, if any, has a slot
	assign adv = valid_s1 && (!step.emit || out_free);

	u8d_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.stream   (stream),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	// decode and accumulate; state moves only when the byte is consumed
	u8d_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_s1 (byte_s1),
		.adv     (adv),
		.step    (step)
	);

	u8d_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (adv && step.emit),
		.res    (step.res),
		.free   (out_free),
		.chars  (chars)
	);
endmodule
